### src/vtp_pkg.sv
package vtp_pkg;

    // Display command codes
    typedef enum logic [3:0] {
        CMD_NONE    = 4'd0,
        CMD_SAVE    = 4'd1,
        CMD_RESTORE = 4'd2,
        CMD_HIDE    = 4'd3,
        CMD_SHOW    = 4'd4,
        CMD_CURSOR  = 4'd5,
        CMD_SCROLL  = 4'd6,
        CMD_COLORS  = 4'd7,
        CMD_CLS     = 4'd8,
        CMD_CLL     = 4'd9
    } cmd_t;

    // Character codes
    localparam logic [7:0] CH_0  = 8'h30;
    localparam logic [7:0] CH_2  = 8'h32;
    localparam logic [7:0] CH_5  = 8'h35;
    localparam logic [7:0] CH_7  = 8'h37;
    localparam logic [7:0] CH_8  = 8'h38;
    localparam logic [7:0] CH_9  = 8'h39;
    localparam logic [7:0] CH_QM = 8'h3F;
    localparam logic [7:0] CH_UA = 8'h41;
    localparam logic [7:0] CH_UH = 8'h48;
    localparam logic [7:0] CH_UJ = 8'h4A;
    localparam logic [7:0] CH_UK = 8'h4B;
    localparam logic [7:0] CH_UZ = 8'h5A;
    localparam logic [7:0] CH_LA = 8'h61;
    localparam logic [7:0] CH_LH = 8'h68;
    localparam logic [7:0] CH_LL = 8'h6C;
    localparam logic [7:0] CH_LM = 8'h6D;
    localparam logic [7:0] CH_LR = 8'h72;
    localparam logic [7:0] CH_LZ = 8'h7A;

    // SGR color parameter values
    localparam logic [7:0] SGR_REVERSE  = 8'd7;
    localparam logic [7:0] SGR_NORMAL   = 8'd27;
    localparam logic [7:0] SGR_FG_BLACK = 8'd30;
    localparam logic [7:0] SGR_FG_WHITE = 8'd37;
    localparam logic [7:0] SGR_FG_DEF   = 8'd39;
    localparam logic [7:0] SGR_BG_BLACK = 8'd40;
    localparam logic [7:0] SGR_BG_WHITE = 8'd47;
    localparam logic [7:0] SGR_BG_DEF   = 8'd49;

    localparam logic [2:0] PRIV_LEN = 3'd3;
    localparam logic [2:0] PRIV_MAX = 3'd7;
    localparam logic [1:0] PIDX_MAX = 2'd2;

    // Parser state apart from the byte position
    typedef struct packed {
        logic [7:0] first_body_char;
        logic       private_mode;
        logic [2:0] private_progress;
        logic       hide_match;
        logic       show_match;
        logic [7:0] param_first;
        logic [7:0] param_second;
        logic [1:0] param_index;
        logic [7:0] saved_x;
        logic [7:0] saved_y;
    } parse_state_t;

    // One result word
    typedef struct packed {
        cmd_t       command;
        logic       seq_end;
        logic [7:0] new_col;
        logic [7:0] new_row;
        logic [7:0] scroll_top;
        logic [7:0] scroll_bottom;
        logic       set_fg;
        logic       fg_white;
        logic       set_bg;
        logic       bg_white;
    } result_t;

    // Clear sequence state, keep the saved cursor
    function automatic parse_state_t clear_seq(parse_state_t s);
        parse_state_t r;
        r                  = s;
        r.first_body_char  = 8'd0;
        r.private_mode     = 1'b0;
        r.private_progress = 3'd0;
        r.hide_match       = 1'b1;
        r.show_match       = 1'b1;
        r.param_first      = 8'd0;
        r.param_second     = 8'd0;
        r.param_index      = 2'd0;
        return r;
    endfunction

    function automatic logic [7:0] dec_sat(logic [7:0] v);
        return (v != 8'd0) ? 8'(v - 8'd1) : 8'd0;
    endfunction

    // Expected bytes of "25l" / "25h" after '?'
    function automatic logic [7:0] hide_char(logic [1:0] k);
        logic [7:0] c;
        unique case (k)
            2'd0:    c = CH_2;
            2'd1:    c = CH_5;
            default: c = CH_LL;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] show_char(logic [1:0] k);
        logic [7:0] c;
        unique case (k)
            2'd0:    c = CH_2;
            2'd1:    c = CH_5;
            default: c = CH_LH;
        endcase
        return c;
    endfunction

endpackage

### src/vtp_decode.sv
module vtp_decode
    import vtp_pkg::*;
#(
    parameter int BUF_DEPTH = 16
)
(
    input  logic [$clog2(BUF_DEPTH+1)-1:0] pos,
    input  parse_state_t                   st,
    input  logic [7:0]                     seq_byte,
    input  logic [7:0]                     cur_x,
    input  logic [7:0]                     cur_y,
    output logic [$clog2(BUF_DEPTH+1)-1:0] pos_next,
    output parse_state_t                   st_next,
    output result_t                        res
);

    localparam int POS_W = $clog2(BUF_DEPTH+1);

    logic       priv;
    logic       is_let;
    logic       is_dig;
    logic       at_end;
    logic [7:0] digit;
    logic [7:0] p0;
    logic [7:0] p1;

    assign is_let = ((seq_byte >= CH_LA) && (seq_byte <= CH_LZ)) ||
                    ((seq_byte >= CH_UA) && (seq_byte <= CH_UZ));
    assign is_dig = (seq_byte >= CH_0) && (seq_byte <= CH_9);
    assign digit  = 8'(seq_byte - CH_0);
    assign priv   = (pos == POS_W'(2)) ? (seq_byte == CH_QM) : st.private_mode;
    assign at_end = (st.private_progress == 3'd2);
    assign p0     = dec_sat(st.param_first);
    assign p1     = dec_sat(st.param_second);

    // Per-byte state update and result
    always_comb
    begin
        res      = '0;
        st_next  = st;
        pos_next = pos;
        if (pos >= POS_W'(BUF_DEPTH))
        begin
            // overflow: discard the sequence
            st_next     = clear_seq(st);
            pos_next    = '0;
            res.seq_end = 1'b1;
        end
        else if (pos == '0)
        begin
            pos_next = POS_W'(1);
        end
        else if (pos == POS_W'(1))
        begin
            pos_next = POS_W'(2);
            if (seq_byte == CH_7)
            begin
                st_next         = clear_seq(st);
                st_next.saved_x = cur_x;
                st_next.saved_y = cur_y;
                pos_next        = '0;
                res.command     = CMD_SAVE;
                res.seq_end     = 1'b1;
            end
            else if (seq_byte == CH_8)
            begin
                st_next     = clear_seq(st);
                pos_next    = '0;
                res.command = CMD_RESTORE;
                res.seq_end = 1'b1;
                res.new_col = st.saved_x;
                res.new_row = st.saved_y;
            end
        end
        else if (is_let)
        begin
            // terminator
            st_next     = clear_seq(st);
            pos_next    = '0;
            res.seq_end = 1'b1;
            if (priv)
            begin
                if (st.hide_match && at_end && seq_byte == CH_LL)
                    res.command = CMD_HIDE;
                else if (st.show_match && at_end && seq_byte == CH_LH)
                    res.command = CMD_SHOW;
            end
            else
            begin
                unique case (seq_byte)
                    CH_UH:
                    begin
                        res.command = CMD_CURSOR;
                        res.new_col = p1;
                        res.new_row = p0;
                    end
                    CH_LR:
                    begin
                        res.command       = CMD_SCROLL;
                        res.new_col       = p0;
                        res.scroll_top    = p0;
                        res.scroll_bottom = p1;
                    end
                    CH_LM:
                    begin
                        res.command = CMD_COLORS;
                        unique case (st.param_first)
                            SGR_REVERSE:
                            begin
                                res.set_fg   = 1'b1;
                                res.set_bg   = 1'b1;
                                res.bg_white = 1'b1;
                            end
                            SGR_NORMAL:
                            begin
                                res.set_fg   = 1'b1;
                                res.fg_white = 1'b1;
                                res.set_bg   = 1'b1;
                            end
                            SGR_FG_BLACK:
                                res.set_fg = 1'b1;
                            SGR_FG_WHITE, SGR_FG_DEF:
                            begin
                                res.set_fg   = 1'b1;
                                res.fg_white = 1'b1;
                            end
                            SGR_BG_BLACK, SGR_BG_DEF:
                                res.set_bg = 1'b1;
                            SGR_BG_WHITE:
                            begin
                                res.set_bg   = 1'b1;
                                res.bg_white = 1'b1;
                            end
                            default: ;
                        endcase
                    end
                    CH_UJ:
                        if (st.first_body_char == CH_2)
                            res.command = CMD_CLS;
                    CH_UK:
                        if (st.first_body_char == CH_2)
                            res.command = CMD_CLL;
                    default: ;
                endcase
            end
        end
        else
        begin
            // body byte
            pos_next = POS_W'(pos + 1'b1);
            if (pos == POS_W'(2))
            begin
                st_next.first_body_char = seq_byte;
                st_next.private_mode    = priv;
            end
            else if (priv)
            begin
                if (st.private_progress < PRIV_LEN)
                begin
                    if (seq_byte != hide_char(st.private_progress[1:0]))
                        st_next.hide_match = 1'b0;
                    if (seq_byte != show_char(st.private_progress[1:0]))
                        st_next.show_match = 1'b0;
                end
                else
                begin
                    st_next.hide_match = 1'b0;
                    st_next.show_match = 1'b0;
                end
                if (st.private_progress < PRIV_MAX)
                    st_next.private_progress = 3'(st.private_progress + 3'd1);
            end
            // parameter accumulation, times ten by shift and add
            if (is_dig)
            begin
                if (st.param_index == 2'd0)
                    st_next.param_first = 8'((st.param_first << 3) +
                                             (st.param_first << 1) + digit);
                else if (st.param_index == 2'd1)
                    st_next.param_second = 8'((st.param_second << 3) +
                                              (st.param_second << 1) + digit);
            end
            else if (st.param_index < PIDX_MAX)
            begin
                st_next.param_index = 2'(st.param_index + 2'd1);
            end
        end
    end

endmodule

### src/vt100_escape_parser.sv
// Flow: a word accepted on the seq channel is held in the input register and
//   decoded from it; its result word is held in the result register for cmd.
//   While cmd stalls a waiting result, that result holds.
// Throughput: one word per cycle unless cmd stalls; state updates once per word.
// Reset (rst_n low, asynchronous): both channels empty, parser state cleared,
//   saved cursor set to (0, 0).
module vt100_escape_parser
    import vtp_pkg::*;
#(
    parameter int BUF_DEPTH = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       seq_valid,
    output logic       seq_stall,
    input  logic [7:0] seq_byte,
    input  logic [7:0] cur_x,
    input  logic [7:0] cur_y,
    output logic       cmd_valid,
    input  logic       cmd_stall,
    output logic [3:0] command,
    output logic       seq_end,
    output logic [7:0] new_col,
    output logic [7:0] new_row,
    output logic [7:0] scroll_top,
    output logic [7:0] scroll_bottom,
    output logic       set_fg,
    output logic       fg_white,
    output logic       set_bg,
    output logic       bg_white
);

    localparam int POS_W = $clog2(BUF_DEPTH+1);

    logic             in_vld_reg;
    logic [7:0]       byte_reg;
    logic [7:0]       cx_reg;
    logic [7:0]       cy_reg;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    parse_state_t     st_reg;
    parse_state_t     st_next;
    result_t          res_next;
    result_t          res_reg;
    logic             out_vld_reg;
    logic             out_free;
    logic             advance;
    logic             in_take;

    // Handshake
    assign out_free  = !out_vld_reg || !cmd_stall;
    assign advance   = in_vld_reg && out_free;
    assign seq_stall = in_vld_reg && !out_free;
    assign in_take   = seq_valid && !seq_stall;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (in_take)
            in_vld_reg <= 1'b1;
        else if (advance)
            in_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            byte_reg <= seq_byte;
            cx_reg   <= cur_x;
            cy_reg   <= cur_y;
        end
    end

    vtp_decode #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_decode (
        .pos      (pos_reg),
        .st       (st_reg),
        .seq_byte (byte_reg),
        .cur_x    (cx_reg),
        .cur_y    (cy_reg),
        .pos_next (pos_next),
        .st_next  (st_next),
        .res      (res_next)
    );

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            st_reg  <= clear_seq('0);
        end
        else if (advance)
        begin
            pos_reg <= pos_next;
            st_reg  <= st_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (advance)
            out_vld_reg <= 1'b1;
        else if (!cmd_stall)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

    assign cmd_valid     = out_vld_reg;
    assign command       = res_reg.command;
    assign seq_end       = res_reg.seq_end;
    assign new_col       = res_reg.new_col;
    assign new_row       = res_reg.new_row;
    assign scroll_top    = res_reg.scroll_top;
    assign scroll_bottom = res_reg.scroll_bottom;
    assign set_fg        = res_reg.set_fg;
    assign fg_white      = res_reg.fg_white;
    assign set_bg        = res_reg.set_bg;
    assign bg_white      = res_reg.bg_white;

endmodule

### src/vtp_checker.sv
module vtp_checker
    import vtp_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       cmd_valid,
    input logic       cmd_stall,
    input logic [3:0] command,
    input logic       seq_end,
    input logic [7:0] new_col,
    input logic [7:0] new_row,
    input logic [7:0] scroll_top,
    input logic [7:0] scroll_bottom,
    input logic       set_fg,
    input logic       fg_white,
    input logic       set_bg,
    input logic       bg_white
);

    // A stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_stall |=> cmd_valid && $stable(command) && $stable(seq_end))
        else $error("result word changed while stalled");

    // Any real command terminates the sequence
    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && (command != CMD_NONE) |-> seq_end)
        else $error("command without sequence end");

    // Scroll fields only with the scroll command
    a_scroll: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && (command != CMD_SCROLL) |-> (scroll_top == 8'd0) &&
            (scroll_bottom == 8'd0))
        else $error("scroll fields set outside scroll command");

    // Color flags only with the color command
    a_color: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && (command != CMD_COLORS) |-> !set_fg && !fg_white &&
            !set_bg && !bg_white)
        else $error("color flags set outside color command");

    // Cursor fields only with restore, set cursor or scroll
    a_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && (command != CMD_RESTORE) && (command != CMD_CURSOR) &&
            (command != CMD_SCROLL) |-> (new_col == 8'd0) && (new_row == 8'd0))
        else $error("cursor fields set outside cursor commands");

endmodule

bind vt100_escape_parser vtp_checker u_vtp_checker (.*);
